>>> hw/rtl/ssd_pkg.sv
// Shared types, codes and the font table for the seven-segment scan driver.
`default_nettype none

package ssd_pkg;

    // Operation codes carried by an input item
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Buffer merge modes of a page write
    typedef enum logic [1:0] {
        MODE_REPLACE = 2'd0,
        MODE_AND     = 2'd1,
        MODE_OR_INV  = 2'd2,
        MODE_KEEP    = 2'd3
    } write_mode_t;

    localparam int unsigned DIGITS      = 3;
    localparam logic [7:0]  GLYPH_BLANK = 8'hFF;
    localparam logic [7:0]  FONT_FIRST  = 8'h20;
    localparam logic [7:0]  FONT_LAST   = 8'h7B;
    localparam int unsigned FONT_COUNT  = 92;

    // Active-low glyphs for codes 0x20 through 0x7B
    localparam logic [7:0] FONT_ROM [0:FONT_COUNT-1] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfc, 8'h7f, 8'hff,
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h80, 8'h90,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'h43, 8'h89,
        8'hdf, 8'h8f, 8'hf1, 8'hc7, 8'h55, 8'hab, 8'ha3, 8'h8c,
        8'h98, 8'haf, 8'h49, 8'h87, 8'hc1, 8'hc7, 8'h47, 8'hd7,
        8'h91, 8'hed,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hf7, 8'hff,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'h43, 8'h89,
        8'hdf, 8'h8f, 8'hf1, 8'hc7, 8'h55, 8'hab, 8'ha3, 8'h8c,
        8'h98, 8'haf, 8'h49, 8'h87, 8'hc1, 8'hc7, 8'h47, 8'hd7,
        8'h91, 8'hed,
        8'hff
    };

    // Control handed from the top level to each digit lane
    typedef struct packed {
        logic        wr;
        write_mode_t mode;
    } lane_ctrl_t;

    // One display result
    typedef struct packed {
        logic [1:0] digit_index;
        logic [7:0] segments;
    } ssd_result_t;

    // Look up a character; codes outside the font give a blank digit
    function automatic logic [7:0] glyph_of(input logic [7:0] ch);
        logic [7:0] offs;
        offs = ch - FONT_FIRST;
        if (ch < FONT_FIRST || ch > FONT_LAST)
            return GLYPH_BLANK;
        return FONT_ROM[offs[6:0]];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssd_if.sv
// Valid/ready channel interfaces for commands and display results.
`default_nettype none

interface ssd_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [7:0]  char_third;
    logic [7:0]  blink_mask_first;
    logic [7:0]  blink_mask_second;
    logic [7:0]  blink_mask_third;
    logic [15:0] blink_period;
    logic [1:0]  write_mode;

    modport source (
        output valid, op, char_first, char_second, char_third,
               blink_mask_first, blink_mask_second, blink_mask_third,
               blink_period, write_mode,
        input  ready
    );
    modport sink (
        input  valid, op, char_first, char_second, char_third,
               blink_mask_first, blink_mask_second, blink_mask_third,
               blink_period, write_mode,
        output ready
    );
endinterface

interface ssd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] digit_index;
    logic [7:0] segments;

    modport source (output valid, digit_index, segments, input ready);
    modport sink   (input  valid, digit_index, segments, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ssd_lane.sv
// One digit lane: font lookup, buffer merge and blink mask storage.
`default_nettype none

module ssd_lane (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ssd_pkg::lane_ctrl_t ctrl,
    input  wire logic [7:0]        ch,
    input  wire logic [7:0]        blink_mask,
    output logic [7:0]             seg,
    output logic [7:0]             mask
);
    import ssd_pkg::*;

    logic [7:0] glyph;
    logic [7:0] seg_reg;
    logic [7:0] seg_next;
    logic [7:0] mask_reg;

    // Look up the glyph and merge it into the buffer entry
    always_comb
    begin
        glyph = glyph_of(ch);
        case (ctrl.mode)
            MODE_REPLACE: seg_next = glyph;
            MODE_AND:     seg_next = seg_reg & glyph;
            MODE_OR_INV:  seg_next = seg_reg | ~glyph;
            default:      seg_next = seg_reg;
        endcase
    end

    // Hold the entry and mask until the next page write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg  <= GLYPH_BLANK;
            mask_reg <= 8'h00;
        end
        else if (ctrl.wr)
        begin
            seg_reg  <= seg_next;
            mask_reg <= blink_mask;
        end
    end

    assign seg  = seg_reg;
    assign mask = mask_reg;

endmodule

`default_nettype wire

>>> hw/rtl/seven_segment_scan_blink_driver.sv
// Top level: scan counter, blink timer, three digit lanes and result skid stage.
//
//  channel | dir | transfer when           | payload
//  --------+-----+-------------------------+----------------------------------------
//  cmd     | in  | cmd.valid & cmd.ready   | op, chars, blink masks, period, mode
//  disp    | out | disp.valid & disp.ready | digit_index, segments
//
//  One item per cycle while cmd.ready is high. A page write updates all three lanes in the cycle of its
//  transfer; a tick's result is registered before it shows on disp.
//  Reset blanks the buffers, clears masks, scan, timer and phase.
//  A stalled result sits in the output register and one more in the skid
//  register; cmd.ready drops only while the skid register is full.
`default_nettype none

module seven_segment_scan_blink_driver (
    input  wire logic clk,
    input  wire logic rst_n,
    ssd_in_if.sink    cmd,
    ssd_out_if.source disp
);
    import ssd_pkg::*;

    logic        in_xfer;
    logic        tick;
    lane_ctrl_t  lane_ctrl;

    logic [7:0]  lane_ch   [DIGITS];
    logic [7:0]  lane_bm   [DIGITS];
    logic [7:0]  lane_seg  [DIGITS];
    logic [7:0]  lane_mask [DIGITS];

    logic [1:0]  scan_reg;
    logic [1:0]  scan_next;
    logic [15:0] ticks_reg;
    logic [15:0] ticks_next;
    logic [15:0] ticks_inc;
    logic        phase_reg;
    logic        phase_next;
    logic [15:0] period_reg;

    logic [7:0]  sel_seg;
    logic [7:0]  sel_mask;
    ssd_result_t result;

    ssd_result_t out_reg;
    logic        out_valid_reg;
    ssd_result_t skid_reg;
    logic        skid_valid_reg;
    logic        out_free;

    assign cmd.ready = ~skid_valid_reg;
    assign in_xfer   = cmd.valid & cmd.ready;
    assign tick      = in_xfer & (cmd.op == OP_TICK);

    assign lane_ctrl.wr   = in_xfer & (cmd.op == OP_WRITE);
    assign lane_ctrl.mode = write_mode_t'(cmd.write_mode);

    assign lane_ch[0] = cmd.char_first;
    assign lane_ch[1] = cmd.char_second;
    assign lane_ch[2] = cmd.char_third;
    assign lane_bm[0] = cmd.blink_mask_first;
    assign lane_bm[1] = cmd.blink_mask_second;
    assign lane_bm[2] = cmd.blink_mask_third;

    // Run one lane per digit
    for (genvar g = 0; g < DIGITS; g++)
    begin : g_lane
        ssd_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .ch         (lane_ch[g]),
            .blink_mask (lane_bm[g]),
            .seg        (lane_seg[g]),
            .mask       (lane_mask[g])
        );
    end

    // Advance the scan and blink timer on a tick
    always_comb
    begin
        scan_next  = (scan_reg >= 2'd2) ? 2'd0 : scan_reg + 2'd1;
        ticks_inc  = ticks_reg + 16'd1;
        ticks_next = ticks_inc;
        phase_next = phase_reg;
        if (period_reg == 16'd0)
        begin
            phase_next = 1'b0;
        end
        else if (ticks_inc >= period_reg)
        begin
            ticks_next = 16'd0;
            phase_next = ~phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg   <= 2'd0;
            ticks_reg  <= 16'd0;
            phase_reg  <= 1'b0;
            period_reg <= 16'd0;
        end
        else if (tick)
        begin
            scan_reg  <= scan_next;
            ticks_reg <= ticks_next;
            phase_reg <= phase_next;
        end
        else if (lane_ctrl.wr)
        begin
            period_reg <= cmd.blink_period;
        end
    end

    // Merge the lanes: pick the newly scanned digit and apply the blink mask
    always_comb
    begin
        case (scan_next)
            2'd0:    begin sel_seg = lane_seg[0]; sel_mask = lane_mask[0]; end
            2'd1:    begin sel_seg = lane_seg[1]; sel_mask = lane_mask[1]; end
            2'd2:    begin sel_seg = lane_seg[2]; sel_mask = lane_mask[2]; end
            default: begin sel_seg = GLYPH_BLANK; sel_mask = 8'h00;        end
        endcase
        result.digit_index = scan_next;
        result.segments    = phase_next ? (sel_seg | sel_mask) : sel_seg;
    end

    // Hold results in the output register, spill to skid on a stall
    assign out_free = ~out_valid_reg | disp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= tick;
            end
        end
        else if (tick)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (tick)
                out_reg <= result;
        end
        else if (tick)
        begin
            skid_reg <= result;
        end
    end

    assign disp.valid       = out_valid_reg;
    assign disp.digit_index = out_reg.digit_index;
    assign disp.segments    = out_reg.segments;

endmodule

`default_nettype wire

>>> hw/rtl/ssd_checker.sv
// Port-level checks for the seven-segment scan driver, bound to the top level.
`default_nettype none

module ssd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_ready,
    input wire logic       disp_valid,
    input wire logic       disp_ready,
    input wire logic [1:0] digit_index,
    input wire logic [7:0] segments
);
    logic       seen_reg;
    logic [1:0] last_reg;
    logic [1:0] expect_idx;
    logic       disp_xfer;

    assign disp_xfer  = disp_valid & disp_ready;
    assign expect_idx = (last_reg >= 2'd2) ? 2'd0 : last_reg + 2'd1;

    // Track the index of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            last_reg <= 2'd0;
        end
        else if (disp_xfer)
        begin
            seen_reg <= 1'b1;
            last_reg <= digit_index;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid && !disp_ready |=> disp_valid && $stable(digit_index)
            && $stable(segments))
        else $error("stalled result changed");

    // Only digits 0..2 are ever enabled
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        disp_valid |-> digit_index != 2'd3)
        else $error("digit index out of range");

    // Delivered results walk the digits in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        disp_xfer && seen_reg |-> digit_index == expect_idx)
        else $error("scan order broken");

    // Back-pressure only while results are waiting
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> disp_valid)
        else $error("command stalled with no pending result");

endmodule

bind seven_segment_scan_blink_driver ssd_checker u_ssd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_ready   (cmd.ready),
    .disp_valid  (disp.valid),
    .disp_ready  (disp.ready),
    .digit_index (disp.digit_index),
    .segments    (disp.segments)
);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the three-digit seven-segment scan and blink driver.
`default_nettype none

module tb;
    import ssd_pkg::*;

    // One command as the sender sees it
    typedef struct {
        logic        op;
        logic [7:0]  chars [3];
        logic [7:0]  masks [3];
        logic [15:0] period;
        write_mode_t mode;
    } cmd_item_t;

    // Active-low glyphs for codes 0x20 through 0x7B
    localparam logic [7:0] FONT_GLYPH [0:91] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfe,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfc, 8'h7f, 8'hff,
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h80, 8'h90,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'h43, 8'h89,
        8'hdf, 8'h8f, 8'hf1, 8'hc7, 8'h55, 8'hab, 8'ha3, 8'h8c,
        8'h98, 8'haf, 8'h49, 8'h87, 8'hc1, 8'hc7, 8'h47, 8'hd7,
        8'h91, 8'hed,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hf7, 8'hff,
        8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e, 8'h43, 8'h89,
        8'hdf, 8'h8f, 8'hf1, 8'hc7, 8'h55, 8'hab, 8'ha3, 8'h8c,
        8'h98, 8'haf, 8'h49, 8'h87, 8'hc1, 8'hc7, 8'h47, 8'hd7,
        8'h91, 8'hed,
        8'hff
    };

    logic clk;
    logic rst_n;

    ssd_in_if  cmd_ch ();
    ssd_out_if disp_ch ();

    seven_segment_scan_blink_driver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .disp  (disp_ch)
    );

    // Shadow copy of the display state
    logic [1:0]  scan_pos;
    logic [15:0] blink_count;
    logic        blink_odd;
    logic [15:0] blink_len;
    logic [7:0]  seg_shadow [3];
    logic [7:0]  mask_shadow [3];

    ssd_result_t expected_digits [$];

    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold_left;
    int errors;
    int n_ticks;
    int n_writes;
    int n_checked;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] char_glyph(logic [7:0] ch);
        logic [7:0] offs;
        offs = ch - FONT_FIRST;
        if (ch < FONT_FIRST || ch > FONT_LAST)
            return GLYPH_BLANK;
        return FONT_GLYPH[offs[6:0]];
    endfunction

    // Apply one accepted command to the shadow state and queue the expected digit
    task automatic advance_display(cmd_item_t c);
        ssd_result_t r;
        logic [7:0]  g;
        if (c.op == OP_WRITE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                g = char_glyph(c.chars[i]);
                case (c.mode)
                    MODE_REPLACE: seg_shadow[i] = g;
                    MODE_AND:     seg_shadow[i] = seg_shadow[i] & g;
                    MODE_OR_INV:  seg_shadow[i] = seg_shadow[i] | ~g;
                    default:      seg_shadow[i] = seg_shadow[i];
                endcase
                mask_shadow[i] = c.masks[i];
            end
            blink_len = c.period;
            n_writes++;
        end
        else
        begin
            scan_pos = (scan_pos >= 2'd2) ? 2'd0 : scan_pos + 2'd1;
            blink_count = blink_count + 16'd1;
            if (blink_len == 16'd0)
                blink_odd = 1'b0;
            else if (blink_count >= blink_len)
            begin
                blink_count = 16'd0;
                blink_odd = ~blink_odd;
            end
            r.digit_index = scan_pos;
            r.segments = seg_shadow[scan_pos] | (blink_odd ? mask_shadow[scan_pos] : 8'h00);
            expected_digits.push_back(r);
            n_ticks++;
        end
    endtask

    // Offer one command, with random idle cycles ahead of it, and hold until transfer
    task automatic send_cmd(cmd_item_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid             <= 1'b1;
        cmd_ch.op                <= c.op;
        cmd_ch.char_first        <= c.chars[0];
        cmd_ch.char_second       <= c.chars[1];
        cmd_ch.char_third        <= c.chars[2];
        cmd_ch.blink_mask_first  <= c.masks[0];
        cmd_ch.blink_mask_second <= c.masks[1];
        cmd_ch.blink_mask_third  <= c.masks[2];
        cmd_ch.blink_period      <= c.period;
        cmd_ch.write_mode        <= c.mode;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        advance_display(c);
    endtask

    function automatic cmd_item_t tick_cmd();
        cmd_item_t c;
        c.op = OP_TICK;
        for (int i = 0; i < 3; i++)
        begin
            c.chars[i] = 8'($urandom_range(255));
            c.masks[i] = 8'($urandom_range(255));
        end
        c.period = 16'($urandom_range(65535));
        c.mode = write_mode_t'($urandom_range(3));
        return c;
    endfunction

    function automatic cmd_item_t write_cmd(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                            logic [7:0] m0, logic [7:0] m1, logic [7:0] m2,
                                            logic [15:0] period, write_mode_t mode);
        cmd_item_t c;
        c.op = OP_WRITE;
        c.chars = '{c0, c1, c2};
        c.masks = '{m0, m1, m2};
        c.period = period;
        c.mode = mode;
        return c;
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(9) < 7)
            return 8'($urandom_range(8'h7B, 8'h20));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(65535));
            default: return 16'($urandom_range(8, 1));
        endcase
    endfunction

    // Mostly ticks, with page writes sprinkled in
    function automatic cmd_item_t random_cmd();
        if ($urandom_range(99) < 22)
            return write_cmd(pick_char(), pick_char(), pick_char(),
                             pick_mask(), pick_mask(), pick_mask(),
                             pick_period(), write_mode_t'($urandom_range(3)));
        return tick_cmd();
    endfunction

    // Receiver: random stalls plus an optional long hold-off
    initial
    begin
        disp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                disp_ch.ready <= 1'b0;
            end
            else
                disp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each transferred result with the oldest expected digit
    always @(posedge clk)
    begin
        ssd_result_t want;
        if (rst_n && disp_ch.valid && disp_ch.ready)
        begin
            if (expected_digits.size() == 0)
            begin
                $error("unexpected result: digit_index %0d segments %02h",
                       disp_ch.digit_index, disp_ch.segments);
                errors++;
            end
            else
            begin
                want = expected_digits.pop_front();
                n_checked++;
                if (disp_ch.digit_index !== want.digit_index)
                begin
                    $error("digit_index: expected %0d, actual %0d",
                           want.digit_index, disp_ch.digit_index);
                    errors++;
                end
                if (disp_ch.segments !== want.segments)
                begin
                    $error("segments: expected %02h, actual %02h",
                           want.segments, disp_ch.segments);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
    endtask

    // Scan through blank digits straight out of reset
    task automatic test_reset_blank();
        repeat (3) send_cmd(tick_cmd());
    endtask

    // Font edges, every write mode, blink on, off and at the longest period
    task automatic test_write_modes();
        send_cmd(write_cmd(8'h1F, 8'h20, 8'h7B, 8'h00, 8'h00, 8'h00, 16'd0, MODE_REPLACE));
        repeat (3) send_cmd(tick_cmd());
        send_cmd(write_cmd("8", "H", 8'h7C, 8'hFF, 8'h00, 8'hA5, 16'd1, MODE_AND));
        repeat (3) send_cmd(tick_cmd());
        send_cmd(write_cmd(8'hFF, "q", "-", 8'h55, 8'hAA, 8'h0F, 16'hFFFF, MODE_OR_INV));
        repeat (3) send_cmd(tick_cmd());
        send_cmd(write_cmd("1", "b", ".", 8'hF0, 8'hFF, 8'h81, 16'd2, MODE_REPLACE));
        repeat (3) send_cmd(tick_cmd());
        send_cmd(write_cmd(8'h00, 8'h80, "Z", 8'h00, 8'hFF, 8'hFF, 16'd0, MODE_KEEP));
        repeat (3) send_cmd(tick_cmd());
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_cmd(random_cmd());
    endtask

    // Hold the receiver off while ticks keep coming so the input stalls
    task automatic test_output_backpressure();
        sink_hold_left = 60;
        repeat (30) send_cmd(tick_cmd());
    endtask

    // Pause the sender until every expected digit has come back
    task automatic test_drain_pause();
        wait_drained();
        repeat (3) @(posedge clk);
        test_random_traffic(40);
    endtask

    initial
    begin
        errors = 0;
        n_ticks = 0;
        n_writes = 0;
        n_checked = 0;
        sink_hold_left = 0;
        src_idle_pct = 18;
        sink_idle_pct = 77;

        scan_pos = 2'd0;
        blink_count = 16'd0;
        blink_odd = 1'b0;
        blink_len = 16'd0;
        for (int i = 0; i < 3; i++)
        begin
            seg_shadow[i] = GLYPH_BLANK;
            mask_shadow[i] = 8'h00;
        end

        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.op = OP_TICK;
        cmd_ch.char_first = 8'h00;
        cmd_ch.char_second = 8'h00;
        cmd_ch.char_third = 8'h00;
        cmd_ch.blink_mask_first = 8'h00;
        cmd_ch.blink_mask_second = 8'h00;
        cmd_ch.blink_mask_third = 8'h00;
        cmd_ch.blink_period = 16'h0000;
        cmd_ch.write_mode = MODE_REPLACE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_blank();
        test_write_modes();
        test_random_traffic(340);

        src_idle_pct = 77;
        sink_idle_pct = 18;
        test_random_traffic(340);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic(320);

        // Let the last digits come out, then look for strays
        wait_drained();
        repeat (10) @(posedge clk);

        $display("tb: %0d ticks and %0d page writes sent, %0d digits checked",
                 n_ticks, n_writes, n_checked);
        $display("tb: covered font edges, all write modes, blink periods, stalls");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
